// ----- design/lsd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and functions for the low-speed-data cyclic (16,8,5) decoder.
// No dependencies; used by lsd_lane and lsd_cyclic_16_8_decoder.
package lsd_pkg;

    // Parity matrix rows; bit 15 of each row is matrix column 0.
    localparam logic [15:0] PARITY_ROWS [8] = '{
        16'h3C80, 16'h9E40, 16'h4F20, 16'h1B10,
        16'hB108, 16'hE404, 16'hF202, 16'h7901
    };

    localparam int TABLE_SIZE    = 16;
    localparam int CANDS         = 4;   // syndromes examined per search cycle
    localparam int CAND_W        = 2;   // bits to number a candidate within its group
    localparam int SEARCH_CYCLES = 4;   // CANDS * SEARCH_CYCLES covers shifts 0..15
    localparam int SEARCH_W      = 2;

    // Per-word decode status
    localparam logic [1:0] STATUS_CLEAN     = 2'd0;
    localparam logic [1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [1:0] STATUS_FAIL      = 2'd2;

    typedef struct packed {
        logic load;   // take a new codeword
        logic step;   // examine the next group of syndromes
        logic fix;    // apply the correction and recheck
    } lane_ctrl_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] status;
    } lane_result_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } lookup_t;

    // 8-bit syndrome of a 16-bit word
    function automatic logic [7:0] syndrome(input logic [15:0] word);
        logic [7:0] s;
        s = '0;
        for (int r = 0; r < 8; r++) begin
            s[7 - r] = ^(word & PARITY_ROWS[r]);
        end
        return s;
    endfunction

    // Next syndrome: syndrome of the previous one shifted left one place
    function automatic logic [7:0] regen(input logic [7:0] s);
        return syndrome({7'b0, s, 1'b0});
    endfunction

    // Error pattern k: bit 15 alone, or bit 15 plus bit k-1
    function automatic logic [15:0] table_pattern(input logic [3:0] k);
        logic [15:0] p;
        p = 16'h8000;
        if (k != 4'd0) begin
            p = p | (16'h0001 << (k - 4'd1));
        end
        return p;
    endfunction

    // First table entry whose syndrome matches
    function automatic lookup_t lookup(input logic [7:0] s);
        lookup_t res;
        res.hit = 1'b0;
        res.idx = '0;
        for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
            if (syndrome(table_pattern(4'(k))) == s) begin
                res.hit = 1'b1;
                res.idx = 4'(k);
            end
        end
        return res;
    endfunction

    // Rotate right by j places
    function automatic logic [15:0] rotr(input logic [15:0] p, input logic [3:0] j);
        logic [31:0] dbl;
        dbl = {p, p} >> j;
        return dbl[15:0];
    endfunction

endpackage

// ----- design/lsd_lane.sv -----
`timescale 1ns / 1ps
// One decode lane: syndrome, table search over regenerated syndromes, correction.
// Depends on lsd_pkg.
module lsd_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsd_pkg::lane_ctrl_t   ctrl,
    input  logic [15:0]           codeword,
    output lsd_pkg::lane_result_t result
);

    logic [15:0]                     word_reg, word_next;
    logic [7:0]                      syn_reg, syn_next;
    logic [lsd_pkg::SEARCH_W-1:0]    base_reg, base_next;
    logic                            found_reg, found_next;
    logic                            clean_reg, clean_next;
    logic [3:0]                      pat_idx_reg, pat_idx_next;
    logic [3:0]                      rot_reg, rot_next;
    logic [1:0]                      status_reg, status_next;

    logic [7:0]                      cand [lsd_pkg::CANDS];
    lsd_pkg::lookup_t                look [lsd_pkg::CANDS];
    logic                            grp_hit;
    logic [3:0]                      grp_idx;
    logic [lsd_pkg::CAND_W-1:0]      grp_pos;
    logic [15:0]                     fixed_word;

    // Chain of regenerated syndromes examined this cycle
    always_comb
    begin
        cand[0] = syn_reg;
        for (int i = 1; i < lsd_pkg::CANDS; i++) begin
            cand[i] = lsd_pkg::regen(cand[i - 1]);
        end
        for (int i = 0; i < lsd_pkg::CANDS; i++) begin
            look[i] = lsd_pkg::lookup(cand[i]);
        end
    end

    // Pick the earliest hit in the group
    always_comb
    begin
        grp_hit = 1'b0;
        grp_idx = '0;
        grp_pos = '0;
        for (int i = lsd_pkg::CANDS - 1; i >= 0; i--) begin
            if (look[i].hit) begin
                grp_hit = 1'b1;
                grp_idx = look[i].idx;
                grp_pos = lsd_pkg::CAND_W'(i);
            end
        end
    end

    assign fixed_word = word_reg ^ lsd_pkg::rotr(lsd_pkg::table_pattern(pat_idx_reg), rot_reg);

    // Load, search, fix
    always_comb
    begin
        word_next    = word_reg;
        syn_next     = syn_reg;
        base_next    = base_reg;
        found_next   = found_reg;
        clean_next   = clean_reg;
        pat_idx_next = pat_idx_reg;
        rot_next     = rot_reg;
        status_next  = status_reg;
        if (ctrl.load) begin
            word_next  = codeword;
            syn_next   = lsd_pkg::syndrome(codeword);
            clean_next = (lsd_pkg::syndrome(codeword) == 8'd0);
            base_next  = '0;
            found_next = 1'b0;
        end else if (ctrl.step) begin
            syn_next  = lsd_pkg::regen(cand[lsd_pkg::CANDS - 1]);
            base_next = base_reg + 1'b1;
            if (!found_reg && grp_hit) begin
                found_next   = 1'b1;
                pat_idx_next = grp_idx;
                rot_next     = {base_reg, grp_pos};
            end
        end else if (ctrl.fix) begin
            if (clean_reg) begin
                status_next = lsd_pkg::STATUS_CLEAN;
            end else if (!found_reg) begin
                status_next = lsd_pkg::STATUS_FAIL;
            end else begin
                word_next   = fixed_word;
                status_next = (lsd_pkg::syndrome(fixed_word) != 8'd0) ?
                              lsd_pkg::STATUS_FAIL : lsd_pkg::STATUS_CORRECTED;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_reg   <= '0;
            found_reg  <= 1'b0;
            clean_reg  <= 1'b0;
            status_reg <= lsd_pkg::STATUS_CLEAN;
        end else begin
            base_reg   <= base_next;
            found_reg  <= found_next;
            clean_reg  <= clean_next;
            status_reg <= status_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        syn_reg     <= syn_next;
        pat_idx_reg <= pat_idx_next;
        rot_reg     <= rot_next;
    end

    assign result.data_byte = word_reg[15:8];
    assign result.status    = status_reg;

endmodule

// ----- design/lsd_cyclic_16_8_decoder.sv -----
`timescale 1ns / 1ps
// Top level: two decode lanes, sequencer and merge into the output register.
// Depends on lsd_pkg and lsd_lane.
//
//  channel | signals                                            | beat
//  --------+----------------------------------------------------+---------------------------
//  in      | in_valid, in_ready, first_codeword, second_codeword | one codeword pair
//  out     | out_valid, out_ready, data_word, first_status,      | one merged result
//          | second_status, word_valid                          |
//
// An item passes from acceptance to the next acceptance through load and syndrome forming,
// the search (four regenerated syndromes per lane per cycle, sixteen shifts in all),
// correction and recheck, and the merge into the output; no new item is taken meanwhile.
// Reset clears the sequencer and the output valid flag. A stalled output holds its
// register; the lanes wait after the fix cycle until the register frees, while a new
// item is taken as soon as the previous result sits in the output register.
module lsd_cyclic_16_8_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] first_codeword,
    input  logic [15:0] second_codeword,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] data_word,
    output logic [1:0]  first_status,
    output logic [1:0]  second_status,
    output logic        word_valid
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FIX    = 2'd2;
    localparam logic [1:0] ST_MERGE  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [lsd_pkg::SEARCH_W-1:0] step_cnt_reg, step_cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [15:0]                  data_word_reg, data_word_next;
    logic [1:0]                   first_status_reg, first_status_next;
    logic [1:0]                   second_status_reg, second_status_next;
    logic                         word_valid_reg, word_valid_next;

    lsd_pkg::lane_ctrl_t   ctrl;
    lsd_pkg::lane_result_t res_first, res_second;
    logic                  take_in;
    logic                  out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign take_in  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Lanes, one per codeword
    lsd_lane u_lane_first (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .codeword (first_codeword),
        .result   (res_first)
    );

    lsd_lane u_lane_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .codeword (second_codeword),
        .result   (res_second)
    );

    // Sequence the lanes and merge into the output register
    always_comb
    begin
        state_next         = state_reg;
        step_cnt_next      = step_cnt_reg;
        out_valid_next     = out_valid_reg;
        data_word_next     = data_word_reg;
        first_status_next  = first_status_reg;
        second_status_next = second_status_reg;
        word_valid_next    = word_valid_reg;
        ctrl               = '0;

        // Drop the output beat once taken
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take_in) begin
                    ctrl.load     = 1'b1;
                    step_cnt_next = '0;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                ctrl.step     = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == lsd_pkg::SEARCH_W'(lsd_pkg::SEARCH_CYCLES - 1)) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                ctrl.fix   = 1'b1;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (out_free) begin
                    out_valid_next     = 1'b1;
                    data_word_next     = {res_second.data_byte, res_first.data_byte};
                    first_status_next  = res_first.status;
                    second_status_next = res_second.status;
                    word_valid_next    = (res_first.status != lsd_pkg::STATUS_FAIL) &&
                                         (res_second.status != lsd_pkg::STATUS_FAIL);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        data_word_reg     <= data_word_next;
        first_status_reg  <= first_status_next;
        second_status_reg <= second_status_next;
        word_valid_reg    <= word_valid_next;
    end

    assign out_valid     = out_valid_reg;
    assign data_word     = data_word_reg;
    assign first_status  = first_status_reg;
    assign second_status = second_status_reg;
    assign word_valid    = word_valid_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lsd_cyclic_16_8_decoder: codeword pairs in, decoded words out.
// Depends on lsd_pkg (parity rows, status codes) and the decoder RTL.
module tb;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] second;
    } codeword_pair_t;

    typedef struct packed {
        logic [15:0] data;
        logic [1:0]  first_st;
        logic [1:0]  second_st;
        logic        ok;
    } decoded_t;

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  status;
    } lane_out_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] pattern;
    } pattern_hit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] first_codeword = 16'h0000;
    logic [15:0] second_codeword = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] data_word;
    logic [1:0]  first_status;
    logic [1:0]  second_status;
    logic        word_valid;

    codeword_pair_t pending_pairs[$];
    decoded_t       expected_words[$];
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             pairs_queued = 0;
    int             pairs_taken = 0;
    int             errors = 0;

    lsd_cyclic_16_8_decoder DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_codeword  (first_codeword),
        .second_codeword (second_codeword),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_word       (data_word),
        .first_status    (first_status),
        .second_status   (second_status),
        .word_valid      (word_valid)
    );

    always #5 clk = ~clk;

    // Syndrome built column by column: each set word bit toggles its matrix column
    function automatic logic [7:0] parity_check(input logic [15:0] w);
        logic [7:0] s;
        s = 8'h00;
        for (int b = 0; b < 16; b++) begin
            if (w[b]) begin
                for (int r = 0; r < 8; r++) begin
                    s[7 - r] = s[7 - r] ^ lsd_pkg::PARITY_ROWS[r][b];
                end
            end
        end
        return s;
    endfunction

    // First error pattern in table order whose syndrome equals s
    function automatic pattern_hit_t find_pattern(input logic [7:0] s);
        pattern_hit_t res;
        logic [15:0]  p;
        res.hit = 1'b0;
        res.pattern = 16'h0000;
        for (int k = 0; k < 16; k++) begin
            p = (k == 0) ? 16'h8000 : (16'h8000 | (16'h0001 << (k - 1)));
            if (!res.hit && parity_check(p) == s) begin
                res.hit = 1'b1;
                res.pattern = p;
            end
        end
        return res;
    endfunction

    // Correct one codeword: search shifted syndromes, rotate pattern back, recheck
    function automatic lane_out_t correct_codeword(input logic [15:0] w);
        lane_out_t    res;
        logic [7:0]   syn;
        pattern_hit_t found;
        logic [15:0]  pat;
        int           shifts;
        res.word = w;
        res.status = lsd_pkg::STATUS_CLEAN;
        syn = parity_check(w);
        if (syn != 8'h00) begin
            shifts = 0;
            found = find_pattern(syn);
            while (!found.hit && shifts < 15) begin
                shifts++;
                syn = parity_check({7'b0, syn, 1'b0});
                found = find_pattern(syn);
            end
            if (!found.hit) begin
                res.status = lsd_pkg::STATUS_FAIL;
            end else begin
                pat = found.pattern;
                if (shifts > 0) begin
                    pat = (pat >> shifts) | (pat << (16 - shifts));
                end
                res.word = w ^ pat;
                res.status = (parity_check(res.word) != 8'h00) ?
                             lsd_pkg::STATUS_FAIL : lsd_pkg::STATUS_CORRECTED;
            end
        end
        return res;
    endfunction

    function automatic decoded_t decode_pair(input codeword_pair_t pair);
        decoded_t  d;
        lane_out_t a;
        lane_out_t b;
        a = correct_codeword(pair.first);
        b = correct_codeword(pair.second);
        d.data = {b.word[15:8], a.word[15:8]};
        d.first_st = a.status;
        d.second_st = b.status;
        d.ok = (a.status != lsd_pkg::STATUS_FAIL) && (b.status != lsd_pkg::STATUS_FAIL);
        return d;
    endfunction

    // Data byte in the high half, check bits in the low half (identity part of the matrix)
    function automatic logic [15:0] encode_byte(input logic [7:0] d);
        return {d, parity_check({d, 8'h00})};
    endfunction

    // Random received word: mostly codewords with a few flipped bits, some pure noise
    function automatic logic [15:0] random_word();
        logic [15:0] w;
        int          kind;
        int          flips;
        kind = $urandom_range(99);
        w = encode_byte(8'($urandom_range(255)));
        if (kind < 15) flips = 0;
        else if (kind < 55) flips = 1;
        else if (kind < 75) flips = 2;
        else if (kind < 85) flips = 3;
        else begin
            flips = 0;
            w = 16'($urandom);
        end
        for (int i = 0; i < flips; i++) begin
            w[$urandom_range(15)] ^= 1'b1;
        end
        return w;
    endfunction

    task automatic queue_pair(input logic [15:0] a, input logic [15:0] b);
        codeword_pair_t p;
        p.first = a;
        p.second = b;
        pending_pairs = {pending_pairs, p};
        pairs_queued++;
    endtask

    // Hold until every queued beat is taken and every result has come back
    task automatic wait_drained();
        while (pairs_taken != pairs_queued || expected_words.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Input driver: present the next pair when the slot is free, idle at random
    always @(posedge clk or negedge rst_n) begin : drive_in
        codeword_pair_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            first_codeword <= 16'h0000;
            second_codeword <= 16'h0000;
        end else if (!in_valid || in_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_pairs.pop_front();
                in_valid <= 1'b1;
                first_codeword <= nxt.first;
                second_codeword <= nxt.second;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: stall at random
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on each input beat, check each output beat against the oldest prediction
    always @(posedge clk) begin : monitor
        codeword_pair_t pair;
        decoded_t       want;
        decoded_t       got;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                pair.first = first_codeword;
                pair.second = second_codeword;
                expected_words = {expected_words, decode_pair(pair)};
                pairs_taken++;
            end
            if (out_valid && out_ready) begin
                got.data = data_word;
                got.first_st = first_status;
                got.second_st = second_status;
                got.ok = word_valid;
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat data=%h st=%0d/%0d valid=%b",
                             $time, got.data, got.first_st, got.second_st, got.ok);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected data=%h st=%0d/%0d valid=%b",
                                 $time, want.data, want.first_st, want.second_st, want.ok);
                        $display("%0t:          actual   data=%h st=%0d/%0d valid=%b",
                                 $time, got.data, got.first_st, got.second_st, got.ok);
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [15:0] clean;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: light sender idling, heavy receiver stalls
        send_idle_pct = 18;
        recv_idle_pct = 53;
        queue_pair(16'h0000, 16'hFFFF);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(encode_byte(8'hA5), encode_byte(8'h3C));
        // Every single-bit error in the first word, a double error in the second (none for bit 15)
        for (int b = 0; b < 16; b++) begin
            clean = encode_byte(8'($urandom_range(255)));
            queue_pair(clean ^ (16'h0001 << b),
                       encode_byte(8'($urandom_range(255))) ^ 16'h8000 ^ (16'h0001 << b));
        end
        repeat (700) queue_pair(random_word(), random_word());
        wait_drained();

        // Phase two: roles swapped
        send_idle_pct = 53;
        recv_idle_pct = 18;
        repeat (700) queue_pair(random_word(), random_word());
        wait_drained();

        // Phase three: back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (600) queue_pair(random_word(), random_word());
        wait_drained();

        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("lsd_cyclic_16_8_decoder regression: pass");
        end else begin
            $display("lsd_cyclic_16_8_decoder regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("lsd_cyclic_16_8_decoder regression: fail");
        $finish;
    end

endmodule
